// File: hw/rtl/sdrs_pkg.sv
// Shared types and constants of the stall detect and reverse sequencer.
package sdrs_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int SPEED_W        = 16;
    localparam int TIME_IN_W      = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_SPEED_MAX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_TIME_MS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEMAND_SPEED_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEMAND_ACCEL_MIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_SPEED_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_TIME_MS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TIME_MS   = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [14:0] RST_STALL_SPEED_MAX  = 15'd100;
    localparam logic [15:0] RST_STALL_TIME_MS    = 16'd1000;
    localparam logic [14:0] RST_DEMAND_SPEED_MIN = 15'd1000;
    localparam logic [14:0] RST_DEMAND_ACCEL_MIN = 15'd300;
    localparam logic [14:0] RST_MOTION_SPEED_MIN = 15'd500;
    localparam logic [15:0] RST_REVERSE_TIME_MS  = 16'd4000;
    localparam logic [15:0] RST_SETTLE_TIME_MS   = 16'd500;

    // Command issued during the reverse phase.
    localparam logic signed [SPEED_W-1:0] REV_SPEED = -16'sd1000;
    localparam logic signed [SPEED_W-1:0] REV_ACCEL = 16'sd1000;

    localparam logic GEAR_REVERSE = 1'b0;
    localparam logic GEAR_DRIVE   = 1'b1;

    typedef struct packed {
        logic [14:0] stall_speed_max;
        logic [15:0] stall_time_ms;
        logic [14:0] demand_speed_min;
        logic [14:0] demand_accel_min;
        logic [14:0] motion_speed_min;
        logic [15:0] reverse_time_ms;
        logic [15:0] settle_time_ms;
    } t_cfg;

    typedef struct packed {
        logic                      gear_valid;
        logic                      gear_select;
        logic                      override;
        logic signed [SPEED_W-1:0] out_speed;
        logic signed [SPEED_W-1:0] out_accel;
        logic                      stall_detected;
    } t_result;

endpackage

// File: hw/rtl/sdrs_in_if.sv
// Input channel: one drive command word with timestamp and measured velocity.
interface sdrs_in_if;
    import sdrs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [TIME_IN_W-1:0]      time_ms;
    logic signed [SPEED_W-1:0] velocity;
    logic signed [SPEED_W-1:0] nominal_speed;
    logic signed [SPEED_W-1:0] nominal_accel;

    modport source (
        output valid, time_ms, velocity, nominal_speed, nominal_accel,
        input  ready
    );

    modport sink (
        input  valid, time_ms, velocity, nominal_speed, nominal_accel,
        output ready
    );

endinterface

// File: hw/rtl/sdrs_out_if.sv
// Output channel: one issued drive command word with gear and status flags.
interface sdrs_out_if;
    import sdrs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      gear_valid;
    logic                      gear_select;
    logic                      override;
    logic signed [SPEED_W-1:0] out_speed;
    logic signed [SPEED_W-1:0] out_accel;
    logic                      stall_detected;

    modport source (
        output valid, gear_valid, gear_select, override, out_speed, out_accel,
               stall_detected,
        input  ready
    );

    modport sink (
        input  valid, gear_valid, gear_select, override, out_speed, out_accel,
               stall_detected,
        output ready
    );

endinterface

// File: hw/rtl/sdrs_ctrl.sv
// Stall detection and recovery sequencing state with its per-word decision logic.
module sdrs_ctrl
    import sdrs_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  t_cfg                      i_cfg,
    input  logic [TIME_IN_W-1:0]      i_time_ms,
    input  logic signed [SPEED_W-1:0] i_velocity,
    input  logic signed [SPEED_W-1:0] i_nominal_speed,
    input  logic signed [SPEED_W-1:0] i_nominal_accel,
    output t_result                   o_result
);

    localparam int EW = TIME_WIDTH + 1;

    logic                  r_motion_seen, n_motion_seen;
    logic                  r_stall_timing, n_stall_timing;
    logic                  r_recovering, n_recovering;
    logic [TIME_WIDTH-1:0] r_stall_start, n_stall_start;
    logic [TIME_WIDTH-1:0] r_rec_start, n_rec_start;

    logic [TIME_WIDTH-1:0] now;
    logic [TIME_WIDTH-1:0] rec_elapsed;
    logic [TIME_WIDTH-1:0] stall_elapsed;
    logic [16:0]           rec_total;
    logic                  in_reverse;
    logic                  in_settle;
    logic                  moving;
    logic                  demand;
    logic [SPEED_W-1:0]    abs_vel;
    logic                  stationary;
    logic                  stall_expired;

    assign now           = TIME_WIDTH'(i_time_ms);
    assign rec_elapsed   = now - r_rec_start;
    assign stall_elapsed = now - r_stall_start;
    assign rec_total     = 17'(i_cfg.reverse_time_ms) + 17'(i_cfg.settle_time_ms);
    assign in_reverse    = EW'(rec_elapsed) < EW'(i_cfg.reverse_time_ms);
    assign in_settle     = EW'(rec_elapsed) < EW'(rec_total);
    assign stall_expired = EW'(stall_elapsed) >= EW'(i_cfg.stall_time_ms);

    assign moving = i_velocity >= $signed({1'b0, i_cfg.motion_speed_min});
    assign demand = (i_nominal_speed >= $signed({1'b0, i_cfg.demand_speed_min}))
                 && (i_nominal_accel >= $signed({1'b0, i_cfg.demand_accel_min}));
    // The magnitude of the most negative velocity fits as an unsigned value.
    assign abs_vel    = i_velocity[SPEED_W-1] ? SPEED_W'(-i_velocity) : i_velocity;
    assign stationary = abs_vel <= {1'b0, i_cfg.stall_speed_max};

    always_comb begin
        n_motion_seen  = r_motion_seen;
        n_stall_timing = r_stall_timing;
        n_recovering   = r_recovering;
        n_stall_start  = r_stall_start;
        n_rec_start    = r_rec_start;

        o_result.gear_valid     = 1'b0;
        o_result.gear_select    = GEAR_REVERSE;
        o_result.override       = 1'b0;
        o_result.out_speed      = i_nominal_speed;
        o_result.out_accel      = i_nominal_accel;
        o_result.stall_detected = 1'b0;

        if (r_recovering && in_reverse) begin
            o_result.gear_valid  = 1'b1;
            o_result.gear_select = GEAR_REVERSE;
            o_result.override    = 1'b1;
            o_result.out_speed   = REV_SPEED;
            o_result.out_accel   = REV_ACCEL;
        end else if (r_recovering && in_settle) begin
            o_result.gear_valid  = 1'b1;
            o_result.gear_select = GEAR_DRIVE;
            o_result.override    = 1'b1;
            o_result.out_speed   = '0;
            o_result.out_accel   = '0;
        end else begin
            // Passthrough; the word that ends a recovery also shifts into drive.
            if (r_recovering) begin
                o_result.gear_valid  = 1'b1;
                o_result.gear_select = GEAR_DRIVE;
                n_recovering         = 1'b0;
            end
            if (moving) begin
                n_motion_seen = 1'b1;
            end
            if (!(r_motion_seen || moving) || !demand || !stationary) begin
                n_stall_timing = 1'b0;
            end else if (!r_stall_timing) begin
                n_stall_timing = 1'b1;
                n_stall_start  = now;
            end else if (stall_expired) begin
                n_stall_timing          = 1'b0;
                n_recovering            = 1'b1;
                n_rec_start             = now;
                o_result.stall_detected = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion_seen  <= 1'b0;
            r_stall_timing <= 1'b0;
            r_recovering   <= 1'b0;
            r_stall_start  <= '0;
            r_rec_start    <= '0;
        end else if (i_accept) begin
            r_motion_seen  <= n_motion_seen;
            r_stall_timing <= n_stall_timing;
            r_recovering   <= n_recovering;
            r_stall_start  <= n_stall_start;
            r_rec_start    <= n_rec_start;
        end
    end

`ifndef SYNTHESIS
    a_timing_excl_recovery: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_recovering |-> !r_stall_timing)
        else $error("stall timer running during recovery");

    a_armed_by_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_motion_seen |-> (!r_stall_timing && !r_recovering))
        else $error("detection active before motion was seen");

    a_detect_starts_recovery: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_result.stall_detected) |=> r_recovering)
        else $error("detected stall did not start a recovery");
`endif

endmodule

// File: hw/rtl/stall_detect_reverse_sequencer.sv
// Top level of the stall detect and reverse sequencer: configuration, channels, output register.
//
// The block watches a stream of drive command words. Each word on i_cmd carries
// a millisecond timestamp, the latest measured velocity and the nominal commanded
// speed and acceleration; each accepted word yields exactly one word on o_cmd.
// Once forward motion has been seen, a vehicle that stays near standstill under
// demand for stall_time_ms latches a recovery: the following words are replaced
// by a reverse command, then by a drive-and-hold command, and the first word
// after the settle time shifts back into drive and passes the nominal command.
// The result of an accepted word is registered and appears on o_cmd in the cycle
// after acceptance; one word is accepted every cycle while the receiver keeps up:
// the decision logic sits between the input port and a single output register.
// If the receiver stalls, the output register holds its word and i_cmd.ready
// drops until the word is taken; a new word is accepted in the same cycle the
// held one leaves. Synchronous reset clears the detection state, empties the
// output register and restores the configuration registers to their defaults.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data while no
// word is in flight; writes to unknown indexes are ignored.
module stall_detect_reverse_sequencer
    import sdrs_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    sdrs_in_if.sink               i_cmd,
    sdrs_out_if.source            o_cmd
);

    t_cfg    r_cfg;
    t_result ctrl_result;
    t_result r_out;
    logic    r_out_valid;
    logic    accept;

    // The output register can take a new word when empty or when its word leaves now.
    assign i_cmd.ready = !r_out_valid || o_cmd.ready;
    assign accept      = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stall_speed_max  <= RST_STALL_SPEED_MAX;
            r_cfg.stall_time_ms    <= RST_STALL_TIME_MS;
            r_cfg.demand_speed_min <= RST_DEMAND_SPEED_MIN;
            r_cfg.demand_accel_min <= RST_DEMAND_ACCEL_MIN;
            r_cfg.motion_speed_min <= RST_MOTION_SPEED_MIN;
            r_cfg.reverse_time_ms  <= RST_REVERSE_TIME_MS;
            r_cfg.settle_time_ms   <= RST_SETTLE_TIME_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STALL_SPEED_MAX:  r_cfg.stall_speed_max  <= i_cfg_data[14:0];
                CFG_STALL_TIME_MS:    r_cfg.stall_time_ms    <= i_cfg_data;
                CFG_DEMAND_SPEED_MIN: r_cfg.demand_speed_min <= i_cfg_data[14:0];
                CFG_DEMAND_ACCEL_MIN: r_cfg.demand_accel_min <= i_cfg_data[14:0];
                CFG_MOTION_SPEED_MIN: r_cfg.motion_speed_min <= i_cfg_data[14:0];
                CFG_REVERSE_TIME_MS:  r_cfg.reverse_time_ms  <= i_cfg_data;
                CFG_SETTLE_TIME_MS:   r_cfg.settle_time_ms   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    sdrs_ctrl #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_cfg           (r_cfg),
        .i_time_ms       (i_cmd.time_ms),
        .i_velocity      (i_cmd.velocity),
        .i_nominal_speed (i_cmd.nominal_speed),
        .i_nominal_accel (i_cmd.nominal_accel),
        .o_result        (ctrl_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_cmd.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload needs no reset; it is only looked at while the valid flag is set.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= ctrl_result;
        end
    end

    assign o_cmd.valid          = r_out_valid;
    assign o_cmd.gear_valid     = r_out.gear_valid;
    assign o_cmd.gear_select    = r_out.gear_select;
    assign o_cmd.override       = r_out.override;
    assign o_cmd.out_speed      = r_out.out_speed;
    assign o_cmd.out_accel      = r_out.out_accel;
    assign o_cmd.stall_detected = r_out.stall_detected;

`ifndef SYNTHESIS
    a_override_has_gear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.override) |-> (r_out.gear_valid && !r_out.stall_detected))
        else $error("override word without gear command or with a detection flag");

    a_held_word_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_cmd.ready) |-> !i_cmd.ready)
        else $error("input accepted while the output word is stalled");

    a_accept_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted word did not reach the output register");
`endif

endmodule

// File: test/tb_stall_detect_reverse_sequencer.sv
// Self-checking testbench for the stall detect and reverse sequencer.
module tb_stall_detect_reverse_sequencer
    import sdrs_pkg::*;
();

    // The slowest correct run stays far below this many cycles.
    localparam int CYCLE_LIMIT     = 400000;
    localparam int WORDS_PER_BATCH = 155;
    // The block buffers only the word in its output register; these cycles cover anything still in flight.
    localparam int SETTLE_CYCLES   = 3;
    // Index beyond the register map; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;
    // Gear select reads zero whenever no gear command goes out with the word.
    localparam logic NO_GEAR = 1'b0;

    typedef struct packed {
        logic [TIME_IN_W-1:0]      time_ms;
        logic signed [SPEED_W-1:0] velocity;
        logic signed [SPEED_W-1:0] nominal_speed;
        logic signed [SPEED_W-1:0] nominal_accel;
    } t_cmd_word;

    typedef enum logic [1:0] {ROW_WORD, ROW_CHECKED, ROW_CFG} t_row_kind;
    typedef enum logic [1:0] {RUN_STALL, RUN_MOTION, RUN_NOISE} t_run_kind;

    typedef struct packed {
        t_row_kind             kind;
        t_cmd_word             word;
        t_result               want;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
    } t_script_row;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sdrs_in_if  cmd_in ();
    sdrs_out_if cmd_out ();

    stall_detect_reverse_sequencer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_in),
        .o_cmd      (cmd_out)
    );

    // Shadow of the block: its registers and its detection state, kept in step
    // with every accepted word.
    t_cfg        model_cfg;
    logic        saw_motion;
    logic        stall_clock_on;
    logic [31:0] stall_t0;
    logic        in_recovery;
    logic [31:0] recovery_t0;

    // Issued command words that the block still owes us, oldest first.
    t_result pending_cmds[$];

    int send_idle_pct  = 29;
    int recv_idle_pct  = 83;
    bit hold_req       = 1'b0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Works out the word the block issues for one input word and advances the
    // shadow state. Elapsed times wrap modulo 2^32 like the timestamps.
    function automatic t_result predict_issued_cmd(input t_cmd_word w);
        t_result     r;
        logic [31:0] elapsed;
        logic [16:0] speed_mag;
        r             = '0;
        r.out_speed   = w.nominal_speed;
        r.out_accel   = w.nominal_accel;
        if (in_recovery) begin
            elapsed = w.time_ms - recovery_t0;
            if (elapsed < 32'(model_cfg.reverse_time_ms)) begin
                r.gear_valid  = 1'b1;
                r.gear_select = GEAR_REVERSE;
                r.override    = 1'b1;
                r.out_speed   = REV_SPEED;
                r.out_accel   = REV_ACCEL;
                return r;
            end
            if (elapsed < 32'(model_cfg.reverse_time_ms) + 32'(model_cfg.settle_time_ms)) begin
                r.gear_valid  = 1'b1;
                r.gear_select = GEAR_DRIVE;
                r.override    = 1'b1;
                r.out_speed   = '0;
                r.out_accel   = '0;
                return r;
            end
            // Recovery is over: shift into drive and treat the word as a normal one.
            r.gear_valid  = 1'b1;
            r.gear_select = GEAR_DRIVE;
            in_recovery   = 1'b0;
        end
        if ($signed(w.velocity) >= $signed({1'b0, model_cfg.motion_speed_min}))
            saw_motion = 1'b1;
        // Magnitude needs 17 bits so that -32768 stays out of the standstill band.
        speed_mag = w.velocity[15] ? 17'd0 - {w.velocity[15], w.velocity} : {1'b0, w.velocity};
        if (!saw_motion
                || $signed(w.nominal_speed) < $signed({1'b0, model_cfg.demand_speed_min})
                || $signed(w.nominal_accel) < $signed({1'b0, model_cfg.demand_accel_min})) begin
            stall_clock_on = 1'b0;
        end else if (speed_mag <= {2'b00, model_cfg.stall_speed_max}) begin
            if (!stall_clock_on) begin
                stall_clock_on = 1'b1;
                stall_t0       = w.time_ms;
            end else if (w.time_ms - stall_t0 >= 32'(model_cfg.stall_time_ms)) begin
                stall_clock_on   = 1'b0;
                in_recovery      = 1'b1;
                recovery_t0      = w.time_ms;
                r.stall_detected = 1'b1;
            end
        end else begin
            stall_clock_on = 1'b0;
        end
        return r;
    endfunction

    function automatic t_script_row word_row(input logic [31:0] t, input int v, input int s,
            input int a);
        t_script_row row;
        row                    = '0;
        row.kind               = ROW_WORD;
        row.word.time_ms       = t;
        row.word.velocity      = 16'(v);
        row.word.nominal_speed = 16'(s);
        row.word.nominal_accel = 16'(a);
        return row;
    endfunction

    // A word whose issued command is obvious enough to be written out by hand.
    function automatic t_script_row checked_row(input logic [31:0] t, input int v, input int s,
            input int a, input logic gv, input logic gs, input logic ov, input int os,
            input int oa, input logic sd);
        t_script_row row;
        row                     = word_row(t, v, s, a);
        row.kind                = ROW_CHECKED;
        row.want.gear_valid     = gv;
        row.want.gear_select    = gs;
        row.want.override       = ov;
        row.want.out_speed      = 16'(os);
        row.want.out_accel      = 16'(oa);
        row.want.stall_detected = sd;
        return row;
    endfunction

    function automatic t_script_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
            input logic [CFG_DATA_W-1:0] data);
        t_script_row row;
        row          = '0;
        row.kind     = ROW_CFG;
        row.reg_idx  = idx;
        row.reg_data = data;
        return row;
    endfunction

    // Offers one word after a random gap and returns on the edge that accepts it.
    // Valid is left high; the caller drives it again in this same step.
    task automatic send_word(input t_cmd_word w, input bit typed, input t_result want);
        t_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_in.valid         <= 1'b1;
        cmd_in.time_ms       <= w.time_ms;
        cmd_in.velocity      <= w.velocity;
        cmd_in.nominal_speed <= w.nominal_speed;
        cmd_in.nominal_accel <= w.nominal_accel;
        do @(posedge i_clk); while (!cmd_in.ready);
        predicted = predict_issued_cmd(w);
        pending_cmds.push_back(typed ? want : predicted);
    endtask

    // Stops offering words until every issued word has come back.
    task automatic drain_pending();
        cmd_in.valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
    endtask

    // Register writes only happen with nothing in flight; the shadow copy keeps
    // the same field widths, so the top data bit is dropped for the 15-bit registers here too.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        drain_pending();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_STALL_SPEED_MAX:  model_cfg.stall_speed_max  = data[14:0];
            CFG_STALL_TIME_MS:    model_cfg.stall_time_ms    = data;
            CFG_DEMAND_SPEED_MIN: model_cfg.demand_speed_min = data[14:0];
            CFG_DEMAND_ACCEL_MIN: model_cfg.demand_accel_min = data[14:0];
            CFG_MOTION_SPEED_MIN: model_cfg.motion_speed_min = data[14:0];
            CFG_REVERSE_TIME_MS:  model_cfg.reverse_time_ms  = data;
            CFG_SETTLE_TIME_MS:   model_cfg.settle_time_ms   = data;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] speed_max, input logic [15:0] stall_t,
            input logic [15:0] dem_speed, input logic [15:0] dem_accel,
            input logic [15:0] motion, input logic [15:0] rev_t, input logic [15:0] settle_t);
        write_reg(CFG_STALL_SPEED_MAX, speed_max);
        write_reg(CFG_STALL_TIME_MS, stall_t);
        write_reg(CFG_DEMAND_SPEED_MIN, dem_speed);
        write_reg(CFG_DEMAND_ACCEL_MIN, dem_accel);
        write_reg(CFG_MOTION_SPEED_MIN, motion);
        write_reg(CFG_REVERSE_TIME_MS, rev_t);
        write_reg(CFG_SETTLE_TIME_MS, settle_t);
    endtask

    task automatic check_field(input string field, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $error("%s mismatch: expected %0d, got %0d", field, want_v, got_v);
            mismatch_count++;
        end
    endtask

    // Receiver: random stalls, plus a long hold-off on request so that the output
    // register fills and the block has to drop ready on its input.
    initial begin
        int hold_left;
        hold_left     = 0;
        cmd_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = $urandom_range(300, 60);
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                cmd_out.ready <= 1'b0;
            end else begin
                cmd_out.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Every word taken from the block is matched against the oldest pending one.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && cmd_out.valid && cmd_out.ready) begin
            got.gear_valid     = cmd_out.gear_valid;
            got.gear_select    = cmd_out.gear_select;
            got.override       = cmd_out.override;
            got.out_speed      = cmd_out.out_speed;
            got.out_accel      = cmd_out.out_accel;
            got.stall_detected = cmd_out.stall_detected;
            if (pending_cmds.size() == 0) begin
                $error("issued word with nothing pending: speed %0d accel %0d",
                       $signed(got.out_speed), $signed(got.out_accel));
                mismatch_count++;
            end else begin
                want = pending_cmds.pop_front();
                check_field("gear_valid", int'(want.gear_valid), int'(got.gear_valid));
                check_field("gear_select", int'(want.gear_select), int'(got.gear_select));
                check_field("override", int'(want.override), int'(got.override));
                check_field("out_speed", int'($signed(want.out_speed)),
                            int'($signed(got.out_speed)));
                check_field("out_accel", int'($signed(want.out_accel)),
                            int'($signed(got.out_accel)));
                check_field("stall_detected", int'(want.stall_detected),
                            int'(got.stall_detected));
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("stall_detect_reverse_sequencer regression: fail");
            $finish;
        end
    end

    initial begin
        t_script_row script[$];
        t_cmd_word   w;
        t_run_kind   run_kind;
        int          run_left;
        int          pick;
        int          span;
        int          v;
        int          lim;
        logic [31:0] clock_ms;

        cmd_in.valid         <= 1'b0;
        cmd_in.time_ms       <= '0;
        cmd_in.velocity      <= '0;
        cmd_in.nominal_speed <= '0;
        cmd_in.nominal_accel <= '0;
        i_cfg_we             <= 1'b0;
        i_cfg_idx            <= '0;
        i_cfg_data           <= '0;

        model_cfg.stall_speed_max  = RST_STALL_SPEED_MAX;
        model_cfg.stall_time_ms    = RST_STALL_TIME_MS;
        model_cfg.demand_speed_min = RST_DEMAND_SPEED_MIN;
        model_cfg.demand_accel_min = RST_DEMAND_ACCEL_MIN;
        model_cfg.motion_speed_min = RST_MOTION_SPEED_MIN;
        model_cfg.reverse_time_ms  = RST_REVERSE_TIME_MS;
        model_cfg.settle_time_ms   = RST_SETTLE_TIME_MS;
        saw_motion     = 1'b0;
        stall_clock_on = 1'b0;
        stall_t0       = '0;
        in_recovery    = 1'b0;
        recovery_t0    = '0;
        run_kind       = RUN_NOISE;
        run_left       = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, on the reset settings: standstill 100 mm/s, stall 1000 ms,
        // demand 1000 mm/s and 300 mm/s^2, motion 500 mm/s, reverse 4000, settle 500.
        // Nothing arms before forward motion has been seen, even at full demand.
        script.push_back(checked_row(32'd0, 0, 32767, 32767, 1'b0, NO_GEAR, 1'b0,
                                     32767, 32767, 1'b0));
        script.push_back(checked_row(32'd1, -32768, -32768, -32768, 1'b0, NO_GEAR, 1'b0,
                                     -32768, -32768, 1'b0));
        // Just below and exactly at the motion threshold.
        script.push_back(word_row(32'd2, 499, 1000, 300));
        script.push_back(word_row(32'd3, 500, 1000, 300));
        // Standstill band edges: timing starts at 40, 999 ms is not yet enough.
        script.push_back(word_row(32'd40, 100, 1000, 300));
        script.push_back(word_row(32'd1039, -100, 1000, 300));
        // The latching word passes through with the detect flag.
        script.push_back(checked_row(32'd1040, 0, 1000, 300, 1'b0, NO_GEAR, 1'b0,
                                     1000, 300, 1'b1));
        script.push_back(checked_row(32'd1041, 5000, 7, 8, 1'b1, GEAR_REVERSE, 1'b1,
                                     REV_SPEED, REV_ACCEL, 1'b0));
        script.push_back(word_row(32'd5039, 0, 0, 0));
        // Reverse ends at exactly 4000 ms, settle at exactly 4500 ms.
        script.push_back(checked_row(32'd5040, 0, 0, 0, 1'b1, GEAR_DRIVE, 1'b1, 0, 0, 1'b0));
        script.push_back(word_row(32'd5539, 0, 0, 0));
        // The finishing word shifts to drive and runs detection like any other word.
        script.push_back(checked_row(32'd5540, 0, 1000, 300, 1'b1, GEAR_DRIVE, 1'b0,
                                     1000, 300, 1'b0));
        script.push_back(word_row(32'd5600, 101, 1000, 300));
        script.push_back(word_row(32'd5700, 0, 999, 300));
        script.push_back(word_row(32'd5800, 0, 1000, 299));
        // Stall time measured across the 32-bit timestamp wrap.
        script.push_back(word_row(32'hFFFF_FF00, 50, 2000, 400));
        script.push_back(checked_row(32'h0000_02E8, -50, 2000, 400, 1'b0, NO_GEAR, 1'b0,
                                     2000, 400, 1'b1));
        // A timestamp going backwards looks like a huge elapsed time: recovery
        // finishes at once, and a pending stall latches at once.
        script.push_back(checked_row(32'h0000_02E7, 600, -5, 0, 1'b1, GEAR_DRIVE, 1'b0,
                                     -5, 0, 1'b0));
        script.push_back(word_row(32'h0000_0300, 0, 32767, 32767));
        script.push_back(checked_row(32'h0000_0200, 0, 32767, 32767, 1'b0, NO_GEAR, 1'b0,
                                     32767, 32767, 1'b1));
        script.push_back(checked_row(32'h0000_0200, 1, 2, 3, 1'b1, GEAR_REVERSE, 1'b1,
                                     REV_SPEED, REV_ACCEL, 1'b0));
        // With zero stall time the timer still needs a second standstill word.
        script.push_back(cfg_row(CFG_STALL_TIME_MS, 16'd0));
        script.push_back(cfg_row(CFG_UNMAPPED, 16'hFFFF));
        script.push_back(checked_row(32'h0000_1394, 0, 1000, 300, 1'b1, GEAR_DRIVE, 1'b0,
                                     1000, 300, 1'b0));
        script.push_back(checked_row(32'h0000_1394, 0, 1000, 300, 1'b0, NO_GEAR, 1'b0,
                                     1000, 300, 1'b1));
        script.push_back(word_row(32'h0000_1395, 0, 1000, 300));

        foreach (script[i]) begin
            case (script[i].kind)
                ROW_CFG:     write_reg(script[i].reg_idx, script[i].reg_data);
                ROW_CHECKED: send_word(script[i].word, 1'b1, script[i].want);
                default:     send_word(script[i].word, 1'b0, '0);
            endcase
        end

        // Random part: three idling modes, each over four register settings.
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 29 : (mode == 1) ? 83 : 0;
            recv_idle_pct = (mode == 0) ? 83 : (mode == 1) ? 29 : 0;
            for (int batch = 0; batch < 4; batch++) begin
                case (batch)
                    0: apply_settings(16'd100, 16'd20, 16'd1000, 16'd300, 16'd500,
                                      16'd40, 16'd15);
                    1: apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
                    2: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                      16'hFFFF, 16'hFFFF);
                    default: apply_settings(16'($urandom()), 16'($urandom()),
                                            16'($urandom()), 16'($urandom()),
                                            16'($urandom()), 16'($urandom()),
                                            16'($urandom()));
                endcase
                // Time steps scale with the programmed durations so that stall,
                // reverse and settle each span a handful of words.
                span = 1 + (int'(model_cfg.stall_time_ms) + int'(model_cfg.reverse_time_ms)
                            + int'(model_cfg.settle_time_ms)) / 8;
                clock_ms = (batch % 2 == 1) ? $urandom()
                                            : 32'hFFFF_FFFF - 32'($urandom_range(4 * span));
                for (int n = 0; n < WORDS_PER_BATCH; n++) begin
                    if (n == 30)
                        hold_req = 1'b1;
                    if (n == 100)
                        drain_pending();
                    // Words come in runs: mostly standstill under demand, which is
                    // what drives the block into recovery, with motion and noise between.
                    if (run_left == 0) begin
                        pick = $urandom_range(99);
                        if (pick < 65) begin
                            run_kind = RUN_STALL;
                            run_left = $urandom_range(14, 3);
                        end else if (pick < 80) begin
                            run_kind = RUN_MOTION;
                            run_left = $urandom_range(3, 1);
                        end else begin
                            run_kind = RUN_NOISE;
                            run_left = $urandom_range(4, 1);
                        end
                    end
                    run_left--;
                    // Now and then jump anywhere (backwards too) or repeat the timestamp.
                    pick = $urandom_range(99);
                    if (pick < 3)
                        clock_ms = $urandom();
                    else if (pick >= 8)
                        clock_ms = clock_ms + 32'($urandom_range(span, 1));
                    w.time_ms       = clock_ms;
                    w.velocity      = 16'($urandom());
                    w.nominal_speed = 16'($urandom());
                    w.nominal_accel = 16'($urandom());
                    lim = int'(model_cfg.stall_speed_max);
                    case (run_kind)
                        RUN_STALL: begin
                            v    = int'($urandom_range(2 * lim)) - lim;
                            pick = $urandom_range(99);
                            if (pick < 8)
                                v = (pick < 4) ? lim : -lim;
                            else if (pick < 14)
                                v = (pick < 11 && lim < 32767) ? lim + 1 : -lim - 1;
                            w.velocity      = 16'(v);
                            w.nominal_speed = 16'($urandom_range(32767,
                                                                 model_cfg.demand_speed_min));
                            w.nominal_accel = 16'($urandom_range(32767,
                                                                 model_cfg.demand_accel_min));
                            // Occasionally miss the demand by one to break the run.
                            pick = $urandom_range(99);
                            if (pick < 4)
                                w.nominal_speed = 16'(int'(model_cfg.demand_speed_min) - 1);
                            else if (pick < 8)
                                w.nominal_accel = 16'(int'(model_cfg.demand_accel_min) - 1);
                        end
                        RUN_MOTION: begin
                            v = int'($urandom_range(32767, model_cfg.motion_speed_min));
                            if ($urandom_range(9) == 0)
                                v = int'(model_cfg.motion_speed_min) - 1;
                            w.velocity = 16'(v);
                        end
                        default: ;
                    endcase
                    send_word(w, 1'b0, '0);
                end
            end
        end

        drain_pending();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("stall_detect_reverse_sequencer regression: pass");
        else
            $display("stall_detect_reverse_sequencer regression: fail");
        $finish;
    end

endmodule
